>>> rtl/fqp_pkg.sv
// fqp_pkg: shared types, sizes and the ieee equality function for the promote queue
// no dependencies; imported by every module of the block
`default_nettype none

package fqp_pkg;

    // queue size and derived widths
    localparam int DEPTH  = 16;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int WORD_W = 32;
    localparam int OCC_W  = 5;

    typedef enum logic [1:0] {
        OP_ENQ     = 2'd0,
        OP_DEQ     = 2'd1,
        OP_PEEK    = 2'd2,
        OP_PROMOTE = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        RES_OK       = 2'd0,
        RES_EMPTY    = 2'd1,
        RES_FULL     = 2'd2,
        RES_NOTFOUND = 2'd3
    } res_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic execute;
    } cmd_t;

    localparam logic [WORD_W-1:0] EXP_MASK  = 32'h7F80_0000;
    localparam logic [WORD_W-1:0] MANT_MASK = 32'h007F_FFFF;
    localparam logic [WORD_W-1:0] MAG_MASK  = 32'h7FFF_FFFF;

    function automatic logic is_nan(input logic [WORD_W-1:0] w);
        return ((w & EXP_MASK) == EXP_MASK) && ((w & MANT_MASK) != '0);
    endfunction

    // +0 equals -0, nan equals nothing
    function automatic logic ieee_equal(input logic [WORD_W-1:0] a,
                                        input logic [WORD_W-1:0] b);
        logic eq;
        eq = 1'b0;
        if (is_nan(a) || is_nan(b))
            eq = 1'b0;
        else if (((a & MAG_MASK) == '0) && ((b & MAG_MASK) == '0))
            eq = 1'b1;
        else
            eq = (a == b);
        return eq;
    endfunction

endpackage

`default_nettype wire

>>> rtl/fqp_ctrl.sv
// fqp_ctrl: two-state sequencer that captures a word and then executes it
// depends on fqp_pkg
`default_nettype none

module fqp_ctrl
    import fqp_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  wire logic out_ready,
    output cmd_t      cmd
);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || out_ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready    = 1'b0;
        cmd.capture = 1'b0;
        cmd.execute = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            S_EXEC:
            begin
                cmd.execute = out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.execute)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // a result is never overwritten before it is taken
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !cmd.execute)
        else $error("result register overwritten while held");

    // every captured word is executed in a later cycle
    a_capture_then_exec: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> (state_reg == S_EXEC))
        else $error("capture not followed by execute state");

    // a new result shows up right after execution
    a_exec_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.execute |=> out_valid_reg)
        else $error("execute did not raise out_valid");

endmodule

`default_nettype wire

>>> rtl/fqp_datapath.sv
// fqp_datapath: row of entry cells, parallel promote match, count and result register
// depends on fqp_pkg; driven by fqp_ctrl commands
`default_nettype none

module fqp_datapath
    import fqp_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire cmd_t              cmd,
    input  wire logic [1:0]        action,
    input  wire logic [WORD_W-1:0] value,
    output logic [1:0]             status,
    output logic [WORD_W-1:0]      data,
    output logic [OCC_W-1:0]       occupancy
);

    logic [WORD_W-1:0] entries_reg [DEPTH];
    logic [WORD_W-1:0] entries_next [DEPTH];
    logic [CNT_W-1:0]  count_reg, count_next;
    op_t               op_reg;
    logic [WORD_W-1:0] value_reg;

    logic [1:0]        status_reg, status_next;
    logic [WORD_W-1:0] data_reg, data_next;
    logic [OCC_W-1:0]  occ_reg;

    logic [DEPTH-1:0]  match;
    logic [DEPTH-1:0]  first;
    logic [DEPTH-1:0]  upto_hit;
    logic              found;
    logic [WORD_W-1:0] hit_val;
    logic              is_empty;
    logic              is_full;

    assign is_empty = (count_reg == '0);
    assign is_full  = (count_reg == CNT_W'(DEPTH));

    // compare every live cell at once, pick the one nearest the head
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
            match[i] = (CNT_W'(i) < count_reg) && ieee_equal(entries_reg[i], value_reg);
    end

    assign first    = match & (~match + DEPTH'(1));
    assign upto_hit = first | (first - DEPTH'(1));
    assign found    = |match;

    always_comb
    begin
        hit_val = '0;
        for (int i = 0; i < DEPTH; i++)
            hit_val = hit_val | ({WORD_W{first[i]}} & entries_reg[i]);
    end

    always_comb
    begin
        entries_next = entries_reg;
        count_next   = count_reg;
        status_next  = RES_OK;
        data_next    = '0;
        case (op_reg)
            OP_ENQ:
            begin
                if (is_full)
                    status_next = RES_FULL;
                else
                begin
                    for (int k = 0; k < DEPTH; k++)
                        if (count_reg == CNT_W'(k))
                            entries_next[k] = value_reg;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            OP_DEQ:
            begin
                if (is_empty)
                    status_next = RES_EMPTY;
                else
                begin
                    data_next = entries_reg[0];
                    for (int k = 0; k < DEPTH - 1; k++)
                        entries_next[k] = entries_reg[k + 1];
                    count_next = count_reg - CNT_W'(1);
                end
            end
            OP_PEEK:
            begin
                if (is_empty)
                    status_next = RES_EMPTY;
                else
                    data_next = entries_reg[0];
            end
            default:
            begin
                // promote: cells up to the hit move back by one, hit goes to the head
                if (!found)
                    status_next = RES_NOTFOUND;
                else
                begin
                    entries_next[0] = hit_val;
                    for (int k = 1; k < DEPTH; k++)
                        if (upto_hit[k])
                            entries_next[k] = entries_reg[k - 1];
                end
            end
        endcase
    end

    // captured word and entry cells
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg    <= op_t'(action);
            value_reg <= value;
        end
        if (cmd.execute)
            entries_reg <= entries_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            status_reg <= RES_OK;
            data_reg   <= '0;
            occ_reg    <= '0;
        end
        else if (cmd.execute)
        begin
            count_reg  <= count_next;
            status_reg <= status_next;
            data_reg   <= data_next;
            occ_reg    <= OCC_W'(count_next);
        end
    end

    assign status    = status_reg;
    assign data      = data_reg;
    assign occupancy = occ_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    a_data_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (data_reg != '0) |-> (status_reg == RES_OK))
        else $error("nonzero data with error status");

    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.execute |=> (count_reg == $past(count_reg)))
        else $error("count changed without execute");

    a_deq_count: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.execute && op_reg == OP_DEQ && !is_empty)
            |=> (count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("dequeue did not lower the count");

endmodule

`default_nettype wire

>>> rtl/fifo_queue_with_promote_top.sv
// fifo_queue_with_promote_top: top level of the promote queue
// depends on fqp_pkg, fqp_ctrl and fqp_datapath
`default_nettype none

// Bounded queue of DEPTH (16) 32-bit float words with enqueue, dequeue, peek and
// promote. Every input word is first captured and then executed against the entry
// cells; no new word is taken until the last one has executed. The execute cycle
// compares the search value against all live cells in
// parallel (ieee equality: +0 equals -0, nan matches nothing), picks the match
// nearest the head and rotates it to the front in the same cycle. A finished
// result sits in an output register; the next word is accepted while it waits,
// and execution holds only if that register is still occupied. Each word gives
// exactly one result: status, data (dequeued or peeked value, else zero) and the
// occupancy after the operation. Enqueue on a full queue is dropped with a full
// status; dequeue or peek on an empty queue returns zero with an empty status.
// Entry cells are not reset, only count and outputs, so no clearing pass is needed.

module fifo_queue_with_promote_top
    import fqp_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [1:0]        action,
    input  wire logic [WORD_W-1:0] value,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [1:0]             status,
    output logic [WORD_W-1:0]      data,
    output logic [OCC_W-1:0]       occupancy
);

    cmd_t cmd;

    // sequencer: capture cycle, execute cycle, result handshake
    fqp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    // entry cells, match logic and result register
    fqp_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .action    (action),
        .value     (value),
        .status    (status),
        .data      (data),
        .occupancy (occupancy)
    );

endmodule

`default_nettype wire

>>> bench/fifo_queue_with_promote_top_tb.sv
// fifo_queue_with_promote_top_tb: self-checking bench for the promote queue
// holds a scoreboard class that tracks queue contents and a top module that drives the block
// depends on fqp_pkg and fifo_queue_with_promote_top
`timescale 1ns / 100ps

typedef struct {
    fqp_pkg::res_t     status;
    logic [31:0]       data;
    logic [4:0]        occ;
} queue_outcome_t;

class promote_queue_scoreboard;
    logic [31:0]    slots [fqp_pkg::DEPTH];
    int unsigned    fill;
    queue_outcome_t owed [$];
    int unsigned    errors;
    int unsigned    checked;
    int unsigned    full_drops;
    int unsigned    empty_hits;
    int unsigned    moved;
    int unsigned    misses;

    function new();
        fill       = 0;
        errors     = 0;
        checked    = 0;
        full_drops = 0;
        empty_hits = 0;
        moved      = 0;
        misses     = 0;
    endfunction

    // float compare: nan matches nothing, both zeros match
    function bit float_match(logic [31:0] a, logic [31:0] b);
        bit a_nan;
        bit b_nan;
        a_nan = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
        b_nan = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
        if (a_nan || b_nan)
            return 1'b0;
        if ((a[30:0] == 31'd0) && (b[30:0] == 31'd0))
            return 1'b1;
        return a == b;
    endfunction

    // apply one accepted word to the queue copy and queue up its result
    function void note_word(fqp_pkg::op_t op, logic [31:0] v);
        queue_outcome_t o;
        int             i;
        int             k;
        int             hit_at;
        logic [31:0]    hit;
        o.status = fqp_pkg::RES_OK;
        o.data   = '0;
        case (op)
            fqp_pkg::OP_ENQ:
                if (fill >= fqp_pkg::DEPTH)
                    o.status = fqp_pkg::RES_FULL;
                else
                begin
                    slots[fill] = v;
                    fill++;
                end
            fqp_pkg::OP_DEQ:
                if (fill == 0)
                    o.status = fqp_pkg::RES_EMPTY;
                else
                begin
                    o.data = slots[0];
                    for (i = 1; i < fill; i++)
                        slots[i-1] = slots[i];
                    fill--;
                end
            fqp_pkg::OP_PEEK:
                if (fill == 0)
                    o.status = fqp_pkg::RES_EMPTY;
                else
                    o.data = slots[0];
            default:
            begin
                hit_at = -1;
                for (i = 0; i < fill; i++)
                    if (hit_at < 0 && float_match(slots[i], v))
                        hit_at = i;
                if (hit_at < 0)
                    o.status = fqp_pkg::RES_NOTFOUND;
                else
                begin
                    hit = slots[hit_at];
                    for (k = hit_at; k > 0; k--)
                        slots[k] = slots[k-1];
                    slots[0] = hit;
                end
            end
        endcase
        o.occ = fill[4:0];
        case (o.status)
            fqp_pkg::RES_FULL:     full_drops++;
            fqp_pkg::RES_EMPTY:    empty_hits++;
            fqp_pkg::RES_NOTFOUND: misses++;
            default:               if (op == fqp_pkg::OP_PROMOTE) moved++;
        endcase
        owed.push_back(o);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
        if (errors < 30)
            $display("%0t mismatch on %s: got %h, want %h", $realtime, what, got, want);
        errors++;
    endtask

    task check_result(logic [1:0] st, logic [31:0] d, logic [4:0] occ);
        queue_outcome_t o;
        if (owed.size() == 0)
        begin
            report("unexpected result word", {30'd0, st}, 32'd0);
            return;
        end
        o = owed.pop_front();
        checked++;
        if (st !== o.status)
            report("status", {30'd0, st}, {30'd0, o.status});
        if (d !== o.data)
            report("data", d, o.data);
        if (occ !== o.occ)
            report("occupancy", {27'd0, occ}, {27'd0, o.occ});
    endtask
endclass

module fifo_queue_with_promote_top_tb;
    import fqp_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int RANDOM_WORDS = 1800;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic [1:0]        action;
    logic [WORD_W-1:0] value;
    logic              out_valid;
    logic              out_ready;
    logic [1:0]        status;
    logic [WORD_W-1:0] data;
    logic [OCC_W-1:0]  occupancy;

    promote_queue_scoreboard sb;
    int unsigned cycles;
    int unsigned words_sent;
    // no-idle stretch: both sides run flat out while set
    bit          calm;

    fifo_queue_with_promote_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .action    (action),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .data      (data),
        .occupancy (occupancy)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // watchdog: a hung handshake ends the run here
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still owed", cycles, sb.owed.size());
            $display("fifo_queue_with_promote_top_tb failed");
            $finish;
        end
    end

    // result side: each result draws its own stall, counted down every cycle
    initial
    begin : result_side
        int unsigned rx_hold;
        rx_hold = 0;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                sb.check_result(status, data, occupancy);
                rx_hold = calm ? 0 : $urandom_range(0, 7);
            end
            else if (rx_hold > 0)
                rx_hold--;
            out_ready <= (rx_hold == 0);
        end
    end

    // present one word after a random gap and hold it until the block takes it
    task automatic send_word(input op_t op, input logic [31:0] v);
        int unsigned gap;
        gap = calm ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            // junk on the idle bus must be ignored
            in_valid <= 1'b0;
            action   <= op_t'($urandom_range(0, 3));
            value    <= $urandom();
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        action   <= op;
        value    <= v;
        do
            @(posedge clk);
        while (!in_ready);
        words_sent++;
        sb.note_word(op, v);
    endtask

    // stop sending until every owed result is back, then let the pipe settle
    task automatic drain_results();
        in_valid <= 1'b0;
        while (sb.owed.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    // values with a bias toward zeros, nans, infinities and a small duplicate-prone set
    function automatic logic [31:0] pick_value();
        int unsigned r;
        logic [31:0] special [10];
        special = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
                    32'h7FC0_0000, 32'hFFFF_FFFF, 32'h7F80_0001, 32'h0000_0001,
                    32'h3F80_0000, 32'hBF80_0000};
        r = $urandom_range(0, 99);
        if (r < 25)
            return special[$urandom_range(0, 9)];
        else if (r < 50)
            return 32'h4000_0000 + $urandom_range(0, 3);
        return $urandom();
    endfunction

    // search key: usually something held, sometimes the other zero, else anything
    function automatic logic [31:0] pick_key();
        logic [31:0] k;
        if (sb.fill > 0 && $urandom_range(0, 99) < 60)
        begin
            k = sb.slots[$urandom_range(0, sb.fill - 1)];
            if (k[30:0] == 31'd0 && $urandom_range(0, 1))
                k[31] = ~k[31];
            return k;
        end
        return pick_value();
    endfunction

    initial
    begin : stimulus
        int unsigned n;
        int unsigned phase_left;
        int unsigned r;
        bit          filling;
        op_t         op;

        sb         = new();
        cycles     = 0;
        words_sent = 0;
        calm       = 1'b0;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        action     = OP_ENQ;
        value      = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty queue: peek, dequeue and promote all report their errors
        send_word(OP_PEEK, 32'h1234_5678);
        send_word(OP_DEQ, 32'hFFFF_FFFF);
        send_word(OP_PROMOTE, 32'h0000_0000);

        // one, negative zero, two nans, infinity
        send_word(OP_ENQ, 32'h3F80_0000);
        send_word(OP_ENQ, 32'h8000_0000);
        send_word(OP_ENQ, 32'h7FC0_0000);
        send_word(OP_ENQ, 32'hFFFF_FFFF);
        send_word(OP_ENQ, 32'h7F80_0000);

        // positive zero finds negative zero, a nan finds nothing, then the head itself
        send_word(OP_PROMOTE, 32'h0000_0000);
        send_word(OP_PROMOTE, 32'h7FC0_0000);
        send_word(OP_PROMOTE, 32'h8000_0000);
        send_word(OP_PEEK, 32'h0);

        // fill to the top; the last enqueue is dropped as full
        for (n = 0; n < 12; n++)
            send_word(OP_ENQ, 32'h4100_0000 + (n << 12) + n);
        send_word(OP_DEQ, 32'h0);
        drain_results();

        // random part: fill and drain phases keep the count swinging end to end
        filling    = 1'b0;
        phase_left = 0;
        for (n = 0; n < RANDOM_WORDS; n++)
        begin
            if (phase_left == 0)
            begin
                filling    = ~filling;
                phase_left = $urandom_range(20, 60);
                calm       = ($urandom_range(0, 3) == 0);
            end
            phase_left--;

            r = $urandom_range(0, 99);
            if (r < (filling ? 50 : 15))
                op = OP_ENQ;
            else if (r < 65)
                op = OP_DEQ;
            else if (r < 75)
                op = OP_PEEK;
            else
                op = OP_PROMOTE;

            case (op)
                OP_ENQ:     send_word(op, pick_value());
                OP_PROMOTE: send_word(op, pick_key());
                default:    send_word(op, $urandom());
            endcase

            // hold off once mid run until the block has caught up
            if (n == RANDOM_WORDS / 2)
                drain_results();
        end

        drain_results();
        $display("sent %0d words, checked %0d results", words_sent, sb.checked);
        $display("full drops %0d, empty errors %0d, promotes moved %0d, not found %0d",
                 sb.full_drops, sb.empty_hits, sb.moved, sb.misses);
        if (sb.errors == 0)
            $display("fifo_queue_with_promote_top_tb passed");
        else
            $display("fifo_queue_with_promote_top_tb failed");
        $finish;
    end
endmodule

>>> filelist.f
rtl/fqp_pkg.sv
rtl/fqp_ctrl.sv
rtl/fqp_datapath.sv
rtl/fifo_queue_with_promote_top.sv
bench/fifo_queue_with_promote_top_tb.sv
